@@ rtl/core/dcem_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcem_pkg
// Shared types and constants of the decimating complex echo MAC: beat
// layouts of the request and response channels, register indexes, widths.
// ----------------------------------------------------------------------------
package dcem_pkg;

   // fixed field widths
   localparam int SAMPLE_BITS = 16;
   localparam int ACC_BITS    = 48;
   localparam int INDEX_BITS  = 12;
   localparam int DEC_BITS    = 11;
   localparam int GATE_BITS   = 12;
   localparam int CSR_BITS    = 12;
   localparam int CSR_IDX_BITS = 1;

   // product and product-sum widths
   localparam int PROD_BITS = 2 * SAMPLE_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;

   // defaults of the top-level parameters; store depth must be a power of two
   localparam int RX_DEPTH_DEF       = 4096;
   localparam int MAX_DECIMATION_DEF = 1024;

   // result queue behind the MAC pipeline
   localparam int QUEUE_DEPTH = 8;

   // action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TX   = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DECIMATION = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANGE_GATE = 1'b1;

   // reset values of the registers
   localparam logic [DEC_BITS-1:0]  DECIMATION_RST = 11'd1;
   localparam logic [GATE_BITS-1:0] RANGE_GATE_RST = 12'd0;

   typedef struct packed {
      logic                          action;
      logic [INDEX_BITS-1:0]         load_addr;
      logic signed [SAMPLE_BITS-1:0] load_re;
      logic signed [SAMPLE_BITS-1:0] load_im;
      logic signed [SAMPLE_BITS-1:0] tx_re;
      logic signed [SAMPLE_BITS-1:0] tx_im;
      logic [INDEX_BITS-1:0]         window_offset;
      logic                          last_tx;
   } req_type;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] echo_re;
      logic signed [ACC_BITS-1:0] echo_im;
      logic [INDEX_BITS-1:0]      echo_index;
      logic                       final_res;
   } rsp_type;

   // transmit step travelling beside the store read
   typedef struct packed {
      logic                          valid;
      logic signed [SAMPLE_BITS-1:0] tx_re;
      logic signed [SAMPLE_BITS-1:0] tx_im;
      logic                          last;
   } tx_beat_type;

endpackage

@@ rtl/core/dcem_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcem_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dcem_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ rtl/core/dcem_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcem_mac
// Complex multiply, product sum and saturating accumulate. Counts steps per
// group and pushes one echo beat when a group closes or on the final step.
// ----------------------------------------------------------------------------
module dcem_mac #(
   parameter int MAX_DECIMATION = dcem_pkg::MAX_DECIMATION_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dcem_pkg::tx_beat_type             tx_beat,
   input  logic [2*dcem_pkg::SAMPLE_BITS-1:0] rx_word,
   input  logic [dcem_pkg::DEC_BITS-1:0]     decimation,
   output logic [1:0]                        busy_count,
   output logic                              push,
   output dcem_pkg::rsp_type                 push_data
);
   import dcem_pkg::*;

   localparam int GC_BITS = $clog2(MAX_DECIMATION + 1);
   localparam int DC_BITS = (DEC_BITS > GC_BITS) ? DEC_BITS : GC_BITS;

   // clamp the wide sum into the signed accumulator range
   function automatic logic [ACC_BITS-1:0] sat_acc(input logic [ACC_BITS:0] wide);
      logic [ACC_BITS-1:0] res;
      res = wide[ACC_BITS-1:0];
      if (wide[ACC_BITS] != wide[ACC_BITS-1]) begin
         res = wide[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                              : {1'b0, {(ACC_BITS-1){1'b1}}};
      end
      return res;
   endfunction

   logic signed [SAMPLE_BITS-1:0] rx_re;
   logic signed [SAMPLE_BITS-1:0] rx_im;

   logic                        s2_valid_ff;
   logic                        s2_last_ff;
   logic signed [PROD_BITS-1:0] prod_ac_ff;
   logic signed [PROD_BITS-1:0] prod_bd_ff;
   logic signed [PROD_BITS-1:0] prod_ad_ff;
   logic signed [PROD_BITS-1:0] prod_bc_ff;

   logic                       s3_valid_ff;
   logic                       s3_last_ff;
   logic signed [SUM_BITS-1:0] sum_re_ff;
   logic signed [SUM_BITS-1:0] sum_im_ff;
   logic signed [SUM_BITS-1:0] sum_re_in;
   logic signed [SUM_BITS-1:0] sum_im_in;

   logic [ACC_BITS-1:0]   acc_re_ff;
   logic [ACC_BITS-1:0]   acc_im_ff;
   logic [ACC_BITS-1:0]   acc_re_in;
   logic [ACC_BITS-1:0]   acc_im_in;
   logic [GC_BITS-1:0]    group_count_ff;
   logic [GC_BITS-1:0]    group_count_in;
   logic [INDEX_BITS-1:0] out_pos_ff;
   logic [INDEX_BITS-1:0] out_pos_in;

   logic [DC_BITS-1:0] dec_raw;
   logic [DC_BITS-1:0] dec_eff;
   logic [DC_BITS-1:0] gc_next;
   logic               group_done;
   logic [ACC_BITS-1:0] sat_re;
   logic [ACC_BITS-1:0] sat_im;

   assign rx_re = $signed(rx_word[2*SAMPLE_BITS-1:SAMPLE_BITS]);
   assign rx_im = $signed(rx_word[SAMPLE_BITS-1:0]);

   // stage 2: four partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= tx_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      s2_last_ff <= tx_beat.last;
      prod_ac_ff <= tx_beat.tx_re * rx_re;
      prod_bd_ff <= tx_beat.tx_im * rx_im;
      prod_ad_ff <= tx_beat.tx_re * rx_im;
      prod_bc_ff <= tx_beat.tx_im * rx_re;
   end

   // stage 3: real and imaginary product sums
   assign sum_re_in = {prod_ac_ff[PROD_BITS-1], prod_ac_ff}
                    - {prod_bd_ff[PROD_BITS-1], prod_bd_ff};
   assign sum_im_in = {prod_ad_ff[PROD_BITS-1], prod_ad_ff}
                    + {prod_bc_ff[PROD_BITS-1], prod_bc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_last_ff <= s2_last_ff;
      sum_re_ff  <= sum_re_in;
      sum_im_ff  <= sum_im_in;
   end

   // effective group length: zero acts as one, clamp at the maximum
   always_comb begin
      dec_raw = DC_BITS'(decimation);
      dec_eff = dec_raw;
      if (dec_raw == '0) begin
         dec_eff = DC_BITS'(1);
      end else if (dec_raw > DC_BITS'(MAX_DECIMATION)) begin
         dec_eff = DC_BITS'(MAX_DECIMATION);
      end
   end

   assign gc_next    = DC_BITS'(group_count_ff) + DC_BITS'(1);
   assign group_done = (gc_next >= dec_eff);

   // accumulate with saturation
   assign sat_re = sat_acc({acc_re_ff[ACC_BITS-1], acc_re_ff}
                  + {{(ACC_BITS + 1 - SUM_BITS){sum_re_ff[SUM_BITS-1]}}, sum_re_ff});
   assign sat_im = sat_acc({acc_im_ff[ACC_BITS-1], acc_im_ff}
                  + {{(ACC_BITS + 1 - SUM_BITS){sum_im_ff[SUM_BITS-1]}}, sum_im_ff});

   assign push = s3_valid_ff && (group_done || s3_last_ff);

   always_comb begin
      push_data.echo_re    = sat_re;
      push_data.echo_im    = sat_im;
      push_data.echo_index = out_pos_ff;
      push_data.final_res  = s3_last_ff;
   end

   // next accumulator and group state: clear after each emitted beat
   always_comb begin
      acc_re_in      = acc_re_ff;
      acc_im_in      = acc_im_ff;
      group_count_in = group_count_ff;
      out_pos_in     = out_pos_ff;
      if (push) begin
         acc_re_in      = '0;
         acc_im_in      = '0;
         group_count_in = '0;
         out_pos_in     = s3_last_ff ? '0 : out_pos_ff + INDEX_BITS'(1);
      end else if (s3_valid_ff) begin
         acc_re_in      = sat_re;
         acc_im_in      = sat_im;
         group_count_in = GC_BITS'(gc_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff      <= '0;
         acc_im_ff      <= '0;
         group_count_ff <= '0;
         out_pos_ff     <= '0;
      end else begin
         acc_re_ff      <= acc_re_in;
         acc_im_ff      <= acc_im_in;
         group_count_ff <= group_count_in;
         out_pos_ff     <= out_pos_in;
      end
   end

   assign busy_count = {1'b0, s2_valid_ff} + {1'b0, s3_valid_ff};

endmodule

@@ rtl/core/dcem_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcem_queue
// Result queue between the MAC pipeline and the response channel. Depth
// must be a power of two.
// ----------------------------------------------------------------------------
module dcem_queue #(
   parameter int DEPTH = dcem_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dcem_pkg::rsp_type          push_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output dcem_pkg::rsp_type          rsp_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import dcem_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   rsp_type             entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entries_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign count     = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

   // hold the payload
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/decimating_complex_echo_mac_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimating_complex_echo_mac_core
// Received-sample store with a decimating complex multiply-accumulate over
// transmit steps; emits one saturated echo beat per group.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | beat
//  --------+-----+---------------------+-------------------------------------
//  req     | in  | req_valid/req_ready | req_type: load or transmit step
//  rsp     | out | rsp_valid/rsp_ready | rsp_type: echo value, index, final
//  csr     | in  | csr_wr_en           | csr_index, csr_wdata, no wait
//
//  One request beat per cycle while req_ready is high. A load writes the
//  store at acceptance. A transmit step reads the store (registered RAM
//  read) beside stage 1, multiplies in stage 2, sums in stage 3 and
//  accumulates; its echo beat then enters the 8-entry result queue and shows
//  on rsp once it reaches the queue head. req_ready drops while queue entries
//  plus the three pipeline stages in flight would fill the queue, and during
//  reset. Reset clears the accumulator and counters; the store is not cleared.
// ----------------------------------------------------------------------------
module decimating_complex_echo_mac_core #(
   parameter int RX_DEPTH       = dcem_pkg::RX_DEPTH_DEF,
   parameter int MAX_DECIMATION = dcem_pkg::MAX_DECIMATION_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  dcem_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dcem_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [dcem_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [dcem_pkg::CSR_BITS-1:0]     csr_wdata
);
   import dcem_pkg::*;

   localparam int ADDR_BITS = $clog2(RX_DEPTH);
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_BITS  = QCNT_BITS + 1;

   logic [DEC_BITS-1:0]  decimation_ff;
   logic [GATE_BITS-1:0] range_gate_ff;

   logic                   req_accept;
   logic                   load_en;
   logic                   tx_en;
   logic [INDEX_BITS:0]    rd_sum;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [PROD_BITS-1:0]   rx_word;

   tx_beat_type            s1_beat_ff;
   tx_beat_type            s1_beat_in;

   logic [1:0]             busy_count;
   logic                   push;
   rsp_type                push_data;
   logic [QCNT_BITS-1:0]   queue_count;
   logic [OCC_BITS-1:0]    occupancy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         decimation_ff <= DECIMATION_RST;
         range_gate_ff <= RANGE_GATE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DECIMATION: decimation_ff <= csr_wdata[DEC_BITS-1:0];
            CSR_RANGE_GATE: range_gate_ff <= csr_wdata[GATE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // admit a beat only when every result in flight has a queue slot
   assign occupancy = OCC_BITS'(queue_count) + OCC_BITS'(busy_count)
                    + OCC_BITS'(s1_beat_ff.valid);
   assign req_ready  = !reset && (occupancy < OCC_BITS'(QUEUE_DEPTH));
   assign req_accept = req_valid && req_ready;
   assign load_en    = req_accept && (req_data.action == ACT_LOAD);
   assign tx_en      = req_accept && (req_data.action == ACT_TX);

   // store addresses wrap modulo the store depth
   assign rd_sum  = {1'b0, req_data.window_offset} + {1'b0, range_gate_ff};
   assign rd_addr = ADDR_BITS'(rd_sum);
   assign wr_addr = ADDR_BITS'(req_data.load_addr);

   dcem_ram #(
      .WIDTH (PROD_BITS),
      .DEPTH (RX_DEPTH)
   ) u_rx_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (wr_addr),
      .wr_data ({req_data.load_re, req_data.load_im}),
      .rd_en   (tx_en),
      .rd_addr (rd_addr),
      .rd_data (rx_word)
   );

   // stage 1: transmit sample waits beside the store read
   always_comb begin
      s1_beat_in.valid = tx_en;
      s1_beat_in.tx_re = req_data.tx_re;
      s1_beat_in.tx_im = req_data.tx_im;
      s1_beat_in.last  = req_data.last_tx;
   end

   always_ff @(posedge clock) begin
      s1_beat_ff.tx_re <= s1_beat_in.tx_re;
      s1_beat_ff.tx_im <= s1_beat_in.tx_im;
      s1_beat_ff.last  <= s1_beat_in.last;
      if (reset) begin
         s1_beat_ff.valid <= 1'b0;
      end else begin
         s1_beat_ff.valid <= s1_beat_in.valid;
      end
   end

   dcem_mac #(
      .MAX_DECIMATION (MAX_DECIMATION)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .tx_beat    (s1_beat_ff),
      .rx_word    (rx_word),
      .decimation (decimation_ff),
      .busy_count (busy_count),
      .push       (push),
      .push_data  (push_data)
   );

   dcem_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .count     (queue_count)
   );

   // a push always finds room in the queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> (queue_count < QCNT_BITS'(QUEUE_DEPTH)))
      else $error("result queue overflow");

   // results in flight never exceed the queue depth
   assert property (@(posedge clock) disable iff (reset)
      occupancy <= OCC_BITS'(QUEUE_DEPTH))
      else $error("in-flight results exceed queue depth");

   // a load beat never produces an echo
   assert property (@(posedge clock) disable iff (reset)
      $past(load_en, 3) && !$past(tx_en, 3) |-> !push)
      else $error("echo pushed for a load beat");

endmodule
